@@ rtl/dqo_pkg.sv @@
// Shared types and constants of the dual quadrature odometer.
// Holds the configuration record, controller states, datapath commands and register map.
// No dependencies.
package dqo_pkg;

   // Default width of the pending edge counters
   localparam int PENDING_WIDTH_DEF = 16;

   // Configuration port geometry
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // Register reset values
   localparam logic [31:0] SPEED_SCALE_RST    = 32'd65536;
   localparam logic [15:0] SAMPLE_PERIOD_RST  = 16'd655;
   localparam logic [16:0] FILTER_ALPHA_RST   = 17'd6554;
   localparam logic [17:0] FWD_GAIN_RST       = 18'd63898;
   localparam logic [17:0] REV_GAIN_RST       = 18'd63898;
   localparam logic [15:0] DISTANCE_LIMIT_RST = 16'd10000;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_SPEED_SCALE    = 3'd0,
      REG_SAMPLE_PERIOD  = 3'd1,
      REG_FILTER_ALPHA   = 3'd2,
      REG_FWD_GAIN       = 3'd3,
      REG_REV_GAIN       = 3'd4,
      REG_DISTANCE_LIMIT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [31:0] speed_scale;
      logic [15:0] sample_period;
      logic [16:0] filter_alpha;
      logic [17:0] fwd_gain;
      logic [17:0] rev_gain;
      logic [15:0] distance_limit;
   } cfg_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE,
      ST_PEND,
      ST_RAW,
      ST_FILT,
      ST_RATE,
      ST_SCALE,
      ST_PATH,
      ST_MEAN,
      ST_DHI,
      ST_DLO,
      ST_ACCUM,
      ST_CHECK,
      ST_OUT
   } state_type;

   // Datapath operations, one per cycle
   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LOAD,
      STEP_EDGE,
      STEP_PEND,
      STEP_RAW,
      STEP_FILT,
      STEP_RATE,
      STEP_SCALE,
      STEP_PATH,
      STEP_MEAN,
      STEP_DHI,
      STEP_DLO,
      STEP_ACCUM,
      STEP_CHECK,
      STEP_OUT
   } step_type;

   typedef enum logic {
      SIDE_LEFT,
      SIDE_RIGHT
   } side_type;

   typedef struct packed {
      step_type step;
      side_type side;
   } cmd_type;

endpackage

@@ rtl/dqo_csr.sv @@
// Configuration registers of the dual quadrature odometer, APB-style write and read.
// Depends on dqo_pkg for the register map, reset values and cfg_type.
module dqo_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dqo_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [dqo_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dqo_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output dqo_pkg::cfg_type                    cfg
);
   import dqo_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SPEED_SCALE:    cfg_in.speed_scale    = csr_pwdata[31:0];
            REG_SAMPLE_PERIOD:  cfg_in.sample_period  = csr_pwdata[15:0];
            REG_FILTER_ALPHA:   cfg_in.filter_alpha   = csr_pwdata[16:0];
            REG_FWD_GAIN:       cfg_in.fwd_gain       = csr_pwdata[17:0];
            REG_REV_GAIN:       cfg_in.rev_gain       = csr_pwdata[17:0];
            REG_DISTANCE_LIMIT: cfg_in.distance_limit = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_scale    <= SPEED_SCALE_RST;
         cfg_ff.sample_period  <= SAMPLE_PERIOD_RST;
         cfg_ff.filter_alpha   <= FILTER_ALPHA_RST;
         cfg_ff.fwd_gain       <= FWD_GAIN_RST;
         cfg_ff.rev_gain       <= REV_GAIN_RST;
         cfg_ff.distance_limit <= DISTANCE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back, zero extended
   always_comb begin
      case (reg_idx)
         REG_SPEED_SCALE:    csr_prdata = cfg_ff.speed_scale;
         REG_SAMPLE_PERIOD:  csr_prdata = {16'b0, cfg_ff.sample_period};
         REG_FILTER_ALPHA:   csr_prdata = {15'b0, cfg_ff.filter_alpha};
         REG_FWD_GAIN:       csr_prdata = {14'b0, cfg_ff.fwd_gain};
         REG_REV_GAIN:       csr_prdata = {14'b0, cfg_ff.rev_gain};
         REG_DISTANCE_LIMIT: csr_prdata = {16'b0, cfg_ff.distance_limit};
         default:            csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/dqo_ctrl.sv @@
// Sequencer of the dual quadrature odometer: input handshake, step order, result valid.
// Depends on dqo_pkg for state_type, side_type and cmd_type.
module dqo_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqo_pkg::cmd_type cmd
);
   import dqo_pkg::*;

   state_type state_ff;
   state_type state_in;
   side_type  side_ff;
   side_type  side_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_op ? ST_PEND : ST_EDGE;
               side_in  = SIDE_LEFT;
            end
         end
         ST_EDGE:  state_in = ST_OUT;
         ST_PEND:  state_in = ST_RAW;
         ST_RAW:   state_in = ST_FILT;
         ST_FILT:  state_in = ST_RATE;
         ST_RATE:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_PATH;
         ST_PATH: begin
            if (side_ff == SIDE_LEFT) begin
               state_in = ST_PEND;
               side_in  = SIDE_RIGHT;
            end else begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN:  state_in = ST_DHI;
         ST_DHI:   state_in = ST_DLO;
         ST_DLO:   state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_CHECK;
         ST_CHECK: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs: datapath command
   always_comb begin
      cmd.side = side_ff;
      case (state_ff)
         ST_IDLE:  cmd.step = accept ? STEP_LOAD : STEP_NONE;
         ST_EDGE:  cmd.step = STEP_EDGE;
         ST_PEND:  cmd.step = STEP_PEND;
         ST_RAW:   cmd.step = STEP_RAW;
         ST_FILT:  cmd.step = STEP_FILT;
         ST_RATE:  cmd.step = STEP_RATE;
         ST_SCALE: cmd.step = STEP_SCALE;
         ST_PATH:  cmd.step = STEP_PATH;
         ST_MEAN:  cmd.step = STEP_MEAN;
         ST_DHI:   cmd.step = STEP_DHI;
         ST_DLO:   cmd.step = STEP_DLO;
         ST_ACCUM: cmd.step = STEP_ACCUM;
         ST_CHECK: cmd.step = STEP_CHECK;
         ST_OUT:   cmd.step = out_free ? STEP_OUT : STEP_NONE;
         default:  cmd.step = STEP_NONE;
      endcase
   end

   // Result valid: set on load, drop when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= SIDE_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded when output slot was free");

   a_right_then_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PATH && side_ff == SIDE_RIGHT) |=> (state_ff == ST_MEAN))
      else $error("distance update did not follow right wheel");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op) |=> (state_ff == ST_PEND && side_ff == SIDE_LEFT))
      else $error("sample tick did not start with left wheel");

endmodule

@@ rtl/dqo_dp.sv @@
// Datapath of the dual quadrature odometer: wheel state, shared multiplier, result register.
// Depends on dqo_pkg for cfg_type, cmd_type and the step codes.
module dqo_dp #(
   parameter int PENDING_WIDTH = dqo_pkg::PENDING_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dqo_pkg::cmd_type    cmd,
   input  dqo_pkg::cfg_type    cfg,
   input  logic [3:0]          req_edge_mask,
   input  logic                req_level_a,
   input  logic                req_level_b,
   input  logic                req_level_c,
   input  logic                req_level_d,
   input  logic [31:0]         req_time_us,
   output logic signed [31:0]  rsp_left_speed,
   output logic signed [31:0]  rsp_right_speed,
   output logic signed [47:0]  rsp_distance,
   output logic signed [63:0]  rsp_left_total,
   output logic signed [63:0]  rsp_right_total,
   output logic [31:0]         rsp_left_edge_us,
   output logic [31:0]         rsp_right_edge_us
);
   import dqo_pkg::*;

   localparam int PW = PENDING_WIDTH;
   localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [65:0] S32_MIN = -S32_MAX - 66'sd1;
   localparam logic signed [65:0] S48_MAX = 66'sd140737488355327;
   localparam logic signed [65:0] S48_MIN = -S48_MAX - 66'sd1;
   localparam logic signed [65:0] ROUND_HALF = 66'sd32768;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;
   localparam logic [17:0] RATIO_MAX = 18'd131072;

   // Saturate to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > S32_MAX) begin
         sat32 = S32_MAX[31:0];
      end else if (v < S32_MIN) begin
         sat32 = S32_MIN[31:0];
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   // Saturate to 48 bits
   function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
      if (v > S48_MAX) begin
         sat48 = S48_MAX[47:0];
      end else if (v < S48_MIN) begin
         sat48 = S48_MIN[47:0];
      end else begin
         sat48 = v[47:0];
      end
   endfunction

   // Step a pending count by one, saturating at the signed range
   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p, input logic up);
      logic [PW:0] e;
      e = {p[PW-1], p} + (up ? {{PW{1'b0}}, 1'b1} : {(PW+1){1'b1}});
      if (e[PW] != e[PW-1]) begin
         bump = up ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
      end else begin
         bump = e[PW-1:0];
      end
   endfunction

   // Latched item
   logic [3:0]  mask_ff, mask_in;
   logic [3:0]  lvl_ff, lvl_in;
   logic [31:0] time_ff, time_in;

   // Architectural state
   logic signed [PW-1:0] lpend_ff, lpend_in, rpend_ff, rpend_in;
   logic signed [63:0]   lsum_ff, lsum_in, rsum_ff, rsum_in;
   logic signed [31:0]   lrate_ff, lrate_in, rrate_ff, rrate_in;
   logic signed [47:0]   lpath_ff, lpath_in, rpath_ff, rpath_in;
   logic signed [47:0]   base_ff, base_in;
   logic signed [47:0]   trav_ff, trav_in;
   logic [31:0]          lstamp_ff, lstamp_in, rstamp_ff, rstamp_in;

   // Working registers
   logic signed [65:0]   prod_ff, prod_in;
   logic signed [32:0]   diff_ff, diff_in;
   logic signed [48:0]   delta_ff, delta_in;
   logic signed [49:0]   hi_ff, hi_in;

   // Result register
   logic signed [31:0]   olspeed_ff, olspeed_in, orspeed_ff, orspeed_in;
   logic signed [47:0]   odist_ff, odist_in;
   logic signed [63:0]   oltotal_ff, oltotal_in, ortotal_ff, ortotal_in;
   logic [31:0]          olstamp_ff, olstamp_in, orstamp_ff, orstamp_in;

   // Combinational helpers
   logic signed [PW-1:0] pend_sel;
   logic signed [63:0]   sum_sel;
   logic signed [31:0]   rate_sel;
   logic signed [47:0]   path_sel;
   logic signed [32:0]   mul_a, mul_b;
   logic                 mul_en;
   logic signed [65:0]   prod_rnd;
   logic signed [49:0]   rnd;
   logic signed [64:0]   sum_ext;
   logic signed [63:0]   sum_new;
   logic signed [65:0]   raw_full;
   logic signed [31:0]   raw;
   logic [16:0]          alpha_eff;
   logic [17:0]          ratio_sel, ratio_eff;
   logic signed [48:0]   path_sum;
   logic signed [47:0]   mean;
   logic signed [47:0]   limit_q;
   logic [PW-1:0]        edge_r0, edge_r1, edge_l0, edge_l1;
   logic                 ab_diff, cd_diff;

   // Select the wheel being worked on
   assign pend_sel = (cmd.side == SIDE_RIGHT) ? rpend_ff : lpend_ff;
   assign sum_sel  = (cmd.side == SIDE_RIGHT) ? rsum_ff  : lsum_ff;
   assign rate_sel = (cmd.side == SIDE_RIGHT) ? rrate_ff : lrate_ff;
   assign path_sel = (cmd.side == SIDE_RIGHT) ? rpath_ff : lpath_ff;

   // Clamp calibration factors
   assign alpha_eff = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
   assign ratio_sel = (!delta_ff[48] && (delta_ff != '0)) ? cfg.fwd_gain
                                                          : cfg.rev_gain;
   assign ratio_eff = (ratio_sel > RATIO_MAX) ? RATIO_MAX : ratio_sel;

   // Round the registered product to Q.0 of the shifted value
   assign prod_rnd = prod_ff + ROUND_HALF;
   assign rnd      = prod_rnd[65:16];

   // Saturating total update
   assign sum_ext = 65'(sum_sel) + 65'(pend_sel);
   assign sum_new = (sum_ext[64] != sum_ext[63])
                    ? (sum_ext[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                    : sum_ext[63:0];

   // Raw speed, negated for the right wheel
   assign raw_full = (cmd.side == SIDE_RIGHT) ? -prod_ff : prod_ff;
   assign raw      = sat32(raw_full);

   // Mean of both paths
   assign path_sum = 49'(lpath_ff) + 49'(rpath_ff);
   assign mean     = path_sum[48:1];
   assign limit_q  = {16'b0, cfg.distance_limit, 16'b0};

   // Edge counting, right pins first
   assign ab_diff = lvl_ff[0] ^ lvl_ff[1];
   assign cd_diff = lvl_ff[2] ^ lvl_ff[3];
   assign edge_r0 = mask_ff[0] ? bump(rpend_ff, ab_diff) : rpend_ff;
   assign edge_r1 = mask_ff[1] ? bump(edge_r0, ~ab_diff) : edge_r0;
   assign edge_l0 = mask_ff[2] ? bump(lpend_ff, cd_diff) : lpend_ff;
   assign edge_l1 = mask_ff[3] ? bump(edge_l0, ~cd_diff) : edge_l0;

   // Shared multiplier operands
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.step)
         STEP_PEND: begin
            mul_a = 33'(pend_sel);
            mul_b = {1'b0, cfg.speed_scale};
         end
         STEP_FILT: begin
            mul_a = {16'b0, alpha_eff};
            mul_b = diff_ff;
         end
         STEP_SCALE: begin
            mul_a = 33'(rate_sel);
            mul_b = {17'b0, cfg.sample_period};
         end
         STEP_DHI: begin
            mul_a = delta_ff[48:16];
            mul_b = {15'b0, ratio_eff};
         end
         STEP_DLO: begin
            mul_a = {17'b0, delta_ff[15:0]};
            mul_b = {15'b0, ratio_eff};
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod_in = mul_en ? (mul_a * mul_b) : prod_ff;

   // Step decode
   always_comb begin
      mask_in    = mask_ff;
      lvl_in     = lvl_ff;
      time_in    = time_ff;
      lpend_in   = lpend_ff;
      rpend_in   = rpend_ff;
      lsum_in    = lsum_ff;
      rsum_in    = rsum_ff;
      lrate_in   = lrate_ff;
      rrate_in   = rrate_ff;
      lpath_in   = lpath_ff;
      rpath_in   = rpath_ff;
      base_in    = base_ff;
      trav_in    = trav_ff;
      lstamp_in  = lstamp_ff;
      rstamp_in  = rstamp_ff;
      diff_in    = diff_ff;
      delta_in   = delta_ff;
      hi_in      = hi_ff;
      olspeed_in = olspeed_ff;
      orspeed_in = orspeed_ff;
      odist_in   = odist_ff;
      oltotal_in = oltotal_ff;
      ortotal_in = ortotal_ff;
      olstamp_in = olstamp_ff;
      orstamp_in = orstamp_ff;
      case (cmd.step)
         STEP_LOAD: begin
            mask_in = req_edge_mask;
            lvl_in  = {req_level_d, req_level_c, req_level_b, req_level_a};
            time_in = req_time_us;
         end
         STEP_EDGE: begin
            rpend_in = edge_r1;
            lpend_in = edge_l1;
            if (mask_ff[0] | mask_ff[1]) begin
               rstamp_in = time_ff;
            end
            if (mask_ff[2] | mask_ff[3]) begin
               lstamp_in = time_ff;
            end
         end
         STEP_PEND: begin
            // move pending count into the total and clear it
            if (cmd.side == SIDE_RIGHT) begin
               rsum_in  = sum_new;
               rpend_in = '0;
            end else begin
               lsum_in  = sum_new;
               lpend_in = '0;
            end
         end
         STEP_RAW: begin
            diff_in = 33'(raw) - 33'(rate_sel);
         end
         STEP_RATE: begin
            if (cmd.side == SIDE_RIGHT) begin
               rrate_in = sat32(66'(rate_sel) + 66'(rnd));
            end else begin
               lrate_in = sat32(66'(rate_sel) + 66'(rnd));
            end
         end
         STEP_PATH: begin
            if (cmd.side == SIDE_RIGHT) begin
               rpath_in = sat48(66'(path_sel) + 66'(rnd));
            end else begin
               lpath_in = sat48(66'(path_sel) + 66'(rnd));
            end
         end
         STEP_MEAN: begin
            delta_in = 49'(mean) - 49'(base_ff);
            base_in  = mean;
         end
         STEP_DLO: begin
            hi_in = prod_ff[49:0];
         end
         STEP_ACCUM: begin
            trav_in = sat48(66'(trav_ff) + 66'(hi_ff) + 66'(rnd));
         end
         STEP_CHECK: begin
            // clear path state once the limit is passed
            if (trav_ff > limit_q) begin
               trav_in  = '0;
               lpath_in = '0;
               rpath_in = '0;
               base_in  = '0;
            end
         end
         STEP_OUT: begin
            olspeed_in = lrate_ff;
            orspeed_in = rrate_ff;
            odist_in   = trav_ff;
            oltotal_in = lsum_ff;
            ortotal_in = rsum_ff;
            olstamp_in = lstamp_ff;
            orstamp_in = rstamp_ff;
         end
         default: begin
            diff_in = diff_ff;
         end
      endcase
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         lpend_ff  <= '0;
         rpend_ff  <= '0;
         lsum_ff   <= '0;
         rsum_ff   <= '0;
         lrate_ff  <= '0;
         rrate_ff  <= '0;
         lpath_ff  <= '0;
         rpath_ff  <= '0;
         base_ff   <= '0;
         trav_ff   <= '0;
         lstamp_ff <= '0;
         rstamp_ff <= '0;
      end else begin
         lpend_ff  <= lpend_in;
         rpend_ff  <= rpend_in;
         lsum_ff   <= lsum_in;
         rsum_ff   <= rsum_in;
         lrate_ff  <= lrate_in;
         rrate_ff  <= rrate_in;
         lpath_ff  <= lpath_in;
         rpath_ff  <= rpath_in;
         base_ff   <= base_in;
         trav_ff   <= trav_in;
         lstamp_ff <= lstamp_in;
         rstamp_ff <= rstamp_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      mask_ff    <= mask_in;
      lvl_ff     <= lvl_in;
      time_ff    <= time_in;
      prod_ff    <= prod_in;
      diff_ff    <= diff_in;
      delta_ff   <= delta_in;
      hi_ff      <= hi_in;
      olspeed_ff <= olspeed_in;
      orspeed_ff <= orspeed_in;
      odist_ff   <= odist_in;
      oltotal_ff <= oltotal_in;
      ortotal_ff <= ortotal_in;
      olstamp_ff <= olstamp_in;
      orstamp_ff <= orstamp_in;
   end

   assign rsp_left_speed    = olspeed_ff;
   assign rsp_right_speed   = orspeed_ff;
   assign rsp_distance      = odist_ff;
   assign rsp_left_total    = oltotal_ff;
   assign rsp_right_total   = ortotal_ff;
   assign rsp_left_edge_us  = olstamp_ff;
   assign rsp_right_edge_us = orstamp_ff;

   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_PEND && cmd.side == SIDE_LEFT) |=> (lpend_ff == '0))
      else $error("left pending count not cleared at sample tick");

   a_limit_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_CHECK) |=> (trav_ff == '0 || trav_ff == $past(trav_ff)))
      else $error("distance altered other than by limit clear");

   a_out_dist: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_OUT) |=> (rsp_distance == trav_ff))
      else $error("result distance differs from state");

endmodule

@@ rtl/dual_quadrature_odometer.sv @@
// Top level of the dual quadrature odometer: configuration registers, sequencer, datapath.
// Depends on dqo_pkg, dqo_csr, dqo_ctrl and dqo_dp.
//
// Usage: each req_ beat is either a pin edge item (req_op 0) that counts the flagged
// encoder pins and stamps the wheel with req_time_us, or a sample tick (req_op 1) that
// turns the pending counts into totals, filtered speeds, paths and a calibrated distance.
// Every accepted item produces exactly one rsp_ beat with the state after that item.
// One item is in work at a time. A tick is sequenced around the one shared 33x33
// multiplier, used three times per wheel and twice for the distance, each use followed
// by a step that consumes the product. The result sits in an output register: while it
// waits, req_ready stays high and the next item is taken and worked; that item then waits
// in its last cycle until the output register is free. Configuration is written over
// the csr_ port (byte address 4 * register index); the user must write it only while
// the block is idle, which the block itself does not enforce; pready is always high.
// Reset restores the register defaults, clears all counts, speeds, paths and distance,
// and drops rsp_valid.
module dual_quadrature_odometer #(
   parameter int PENDING_WIDTH = dqo_pkg::PENDING_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [3:0]                          req_edge_mask,
   input  logic                                req_level_a,
   input  logic                                req_level_b,
   input  logic                                req_level_c,
   input  logic                                req_level_d,
   input  logic [31:0]                         req_time_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_left_speed,
   output logic signed [31:0]                  rsp_right_speed,
   output logic signed [47:0]                  rsp_distance,
   output logic signed [63:0]                  rsp_left_total,
   output logic signed [63:0]                  rsp_right_total,
   output logic [31:0]                         rsp_left_edge_us,
   output logic [31:0]                         rsp_right_edge_us,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dqo_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [dqo_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dqo_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import dqo_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // Configuration registers
   dqo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer
   dqo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath
   dqo_dp #(
      .PENDING_WIDTH (PENDING_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_edge_mask     (req_edge_mask),
      .req_level_a       (req_level_a),
      .req_level_b       (req_level_b),
      .req_level_c       (req_level_c),
      .req_level_d       (req_level_d),
      .req_time_us       (req_time_us),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_distance      (rsp_distance),
      .rsp_left_total    (rsp_left_total),
      .rsp_right_total   (rsp_right_total),
      .rsp_left_edge_us  (rsp_left_edge_us),
      .rsp_right_edge_us (rsp_right_edge_us)
   );

endmodule
